// ===== sv/nnd_pkg.sv =====
// Shared constants, codes and item types of the nearest-neighbor downscaler.
`default_nettype none

package nnd_pkg;

    localparam int MAX_SIDE    = 256;
    localparam int FRAME_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int DIM_W       = 9;
    localparam int COUNT_W     = 17;
    localparam int COORD_W     = 8;
    localparam int PIX_W       = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] ST_PIXEL      = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_NO_PIXELS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIZE  = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [DIM_W-1:0]   scaled_width;
        logic [DIM_W-1:0]   scaled_height;
        logic               last_pixel;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic               busy;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DIM_W-1:0]   s;
        logic [COUNT_W-1:0] total;
        logic [DIM_W-1:0]   nw;
        logic [DIM_W-1:0]   nh;
        logic [DIM_W-1:0]   q;
        logic [DIM_W-1:0]   r;
    } t_geom;

endpackage

`default_nettype wire

// ===== sv/nnd_frame_ram.sv =====
// Frame store: single-port-write, registered-read memory for source pixels.
`default_nettype none

module nnd_frame_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [nnd_pkg::ADDR_W-1:0] i_waddr,
    input  logic [nnd_pkg::PIX_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [nnd_pkg::ADDR_W-1:0] i_raddr,
    output logic [nnd_pkg::PIX_W-1:0]  o_rdata
);
    import nnd_pkg::*;

    logic [PIX_W-1:0] r_mem [FRAME_DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/nnd_geometry.sv =====
// Configuration registers and scaled-frame geometry built with a shared serial divider.
`default_nettype none

module nnd_geometry (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [nnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnd_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                          o_restart,
    output nnd_pkg::t_geom                o_geom
);
    import nnd_pkg::*;

    localparam logic [1:0] GS_IDLE = 2'd0;
    localparam logic [1:0] GS_PREP = 2'd1;
    localparam logic [1:0] GS_DIV  = 2'd2;

    localparam logic [1:0] SEL_WIDTH  = 2'd0;
    localparam logic [1:0] SEL_HEIGHT = 2'd1;
    localparam logic [1:0] SEL_STEP   = 2'd2;

    localparam int CNT_W = $clog2(COUNT_W);

    function automatic logic [DIM_W-1:0] eff_side(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_SIDE)) begin
            res = DIM_W'(MAX_SIDE);
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [DIM_W-1:0]   r_cfg_w;
    logic [DIM_W-1:0]   r_cfg_h;
    logic [DIM_W-1:0]   r_cfg_s;
    logic [1:0]         r_state;
    logic [1:0]         r_sel;
    logic [CNT_W-1:0]   r_cnt;

    logic [DIM_W-1:0]   r_w;
    logic [DIM_W-1:0]   r_h;
    logic [DIM_W-1:0]   r_s;
    logic [DIM_W-1:0]   r_d;
    logic [COUNT_W-1:0] r_total;
    logic [COUNT_W-1:0] r_hs;
    logic [DIM_W-1:0]   r_rem;
    logic [COUNT_W-1:0] r_quo;
    logic [DIM_W-1:0]   r_nw;
    logic [DIM_W-1:0]   r_nh;
    logic [DIM_W-1:0]   r_q;
    logic [DIM_W-1:0]   r_r;

    logic               wr_hit;
    logic [DIM_W-1:0]   e_w;
    logic [DIM_W-1:0]   e_h;
    logic [DIM_W-1:0]   e_s;
    logic [DIM_W-1:0]   e_d;
    logic [DIM_W-1:0]   div_divisor;
    logic [DIM_W:0]     shifted;
    logic               fits;
    logic [DIM_W-1:0]   step_rem;
    logic [COUNT_W-1:0] step_quo;
    logic               div_last;

    assign wr_hit = i_cfg_valid && (i_cfg_index == REG_IMAGE_WIDTH ||
                    i_cfg_index == REG_IMAGE_HEIGHT || i_cfg_index == REG_TARGET_SIZE);

    always_comb begin
        e_w         = eff_side(r_cfg_w);
        e_h         = eff_side(r_cfg_h);
        e_s         = eff_side(r_cfg_s);
        e_d         = (e_w > e_h) ? e_w : e_h;
        div_divisor = (r_sel == SEL_STEP) ? r_s : r_d;
        shifted     = {r_rem, r_quo[COUNT_W-1]};
        fits        = shifted >= {1'b0, div_divisor};
        step_rem    = fits ? DIM_W'(shifted - {1'b0, div_divisor}) : DIM_W'(shifted);
        step_quo    = {r_quo[COUNT_W-2:0], fits};
        div_last    = r_cnt == CNT_W'(COUNT_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DIM_W'(256);
            r_cfg_h <= DIM_W'(256);
            r_cfg_s <= DIM_W'(128);
            r_state <= GS_PREP;
            r_sel   <= SEL_WIDTH;
            r_cnt   <= '0;
        end else if (wr_hit) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default:          r_cfg_s <= i_cfg_data;
            endcase
            r_state <= GS_PREP;
        end else begin
            case (r_state)
                GS_PREP: begin
                    r_state <= GS_DIV;
                    r_sel   <= SEL_WIDTH;
                    r_cnt   <= '0;
                end
                GS_DIV: begin
                    if (div_last) begin
                        r_cnt <= '0;
                        case (r_sel)
                            SEL_WIDTH:  r_sel <= SEL_HEIGHT;
                            SEL_HEIGHT: r_sel <= SEL_STEP;
                            default:    r_state <= GS_IDLE;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: r_state <= r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == GS_PREP) begin
            r_w     <= e_w;
            r_h     <= e_h;
            r_s     <= e_s;
            r_d     <= e_d;
            r_total <= COUNT_W'(e_w * e_h);
            r_hs    <= COUNT_W'(e_h * e_s);
            r_quo   <= COUNT_W'(e_w * e_s);
            r_rem   <= '0;
        end else if (r_state == GS_DIV) begin
            if (div_last) begin
                r_rem <= '0;
                case (r_sel)
                    SEL_WIDTH: begin
                        r_nw  <= DIM_W'(step_quo);
                        r_quo <= r_hs;
                    end
                    SEL_HEIGHT: begin
                        r_nh  <= DIM_W'(step_quo);
                        r_quo <= COUNT_W'(r_d);
                    end
                    default: begin
                        r_q <= DIM_W'(step_quo);
                        r_r <= step_rem;
                    end
                endcase
            end else begin
                r_rem <= step_rem;
                r_quo <= step_quo;
            end
        end
    end

    assign o_restart = wr_hit;

    always_comb begin
        o_geom.busy  = r_state != GS_IDLE;
        o_geom.w     = r_w;
        o_geom.h     = r_h;
        o_geom.s     = r_s;
        o_geom.total = r_total;
        o_geom.nw    = r_nw;
        o_geom.nh    = r_nh;
        o_geom.q     = r_q;
        o_geom.r     = r_r;
    end

endmodule

`default_nettype wire

// ===== sv/nearest_neighbor_downscaler.sv =====
// Top level of the nearest-neighbor downscaler: load and fetch control around the frame store.
//
//   Channel   Handshake                    Payload
//   input     start / busy                 i_item (opcode, pixel_in)
//   result    o_result_strobe, no stall    o_result
//   config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A load writes the frame store; a fetch gives its result in the cycle after it is accepted.
// One item can be accepted in every cycle while busy is low.
// After reset and after each register write, busy stays high while the shared serial
// divider works out the scaled size and the source step (three 17-bit divisions).
// Reset clears the load count and the emit position; the frame store is not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

module nearest_neighbor_downscaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nnd_pkg::t_in_item             i_item,
    output logic                          o_result_strobe,
    output nnd_pkg::t_out_item            o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnd_pkg::DIM_W-1:0]     i_cfg_data
);
    import nnd_pkg::*;

    t_geom              geom;
    logic               restart;

    logic [COUNT_W-1:0] r_load_cnt;
    logic [COORD_W-1:0] r_col;
    logic [DIM_W-1:0]   r_row;
    logic [COORD_W-1:0] r_px;
    logic [DIM_W-1:0]   r_rx;
    logic [DIM_W-1:0]   r_py;
    logic [DIM_W-1:0]   r_ry;
    logic               r_res_vld;

    logic [COUNT_W-1:0] n_load_cnt;
    logic [COORD_W-1:0] n_col;
    logic [DIM_W-1:0]   n_row;
    logic [COORD_W-1:0] n_px;
    logic [DIM_W-1:0]   n_rx;
    logic [DIM_W-1:0]   n_py;
    logic [DIM_W-1:0]   n_ry;

    logic [1:0]         r_res_status;
    logic [COORD_W-1:0] r_res_col;
    logic [COORD_W-1:0] r_res_row;
    logic               r_res_last;
    logic [DIM_W-1:0]   r_res_nw;
    logic [DIM_W-1:0]   r_res_nh;

    logic               accept;
    logic               frame_full;
    logic               do_load;
    logic               do_fetch;
    logic [1:0]         fetch_status;
    logic               give_pixel;
    logic [DIM_W-1:0]   col_next;
    logic [DIM_W-1:0]   row_next;
    logic               row_end;
    logic               is_last;
    logic [DIM_W:0]     px_sum;
    logic [DIM_W:0]     rx_sum;
    logic               rx_wrap;
    logic [DIM_W:0]     py_sum;
    logic [DIM_W:0]     ry_sum;
    logic               ry_wrap;
    logic [2*DIM_W-1:0] row_base;
    logic [2*DIM_W-1:0] addr_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PIX_W-1:0]   ram_rdata;

    nnd_geometry u_geometry (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_restart   (restart),
        .o_geom      (geom)
    );

    nnd_frame_ram u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (ADDR_W'(r_load_cnt)),
        .i_wdata (i_item.pixel_in),
        .i_re    (give_pixel),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign busy        = geom.busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        accept     = start && !busy;
        frame_full = r_load_cnt >= geom.total;
        do_load    = accept && i_item.opcode == OP_LOAD && !frame_full;
        do_fetch   = accept && i_item.opcode == OP_FETCH;

        if (!frame_full) begin
            fetch_status = ST_NOT_LOADED;
        end else if (geom.nw == '0 || geom.nh == '0 || r_row >= geom.nh) begin
            fetch_status = ST_NO_PIXELS;
        end else begin
            fetch_status = ST_PIXEL;
        end
        give_pixel = do_fetch && fetch_status == ST_PIXEL;

        row_base  = r_py * geom.w;
        addr_full = row_base + (2*DIM_W)'(r_px);
        rd_addr   = ADDR_W'(addr_full);

        col_next = {1'b0, r_col} + DIM_W'(1);
        row_next = r_row + DIM_W'(1);
        row_end  = col_next >= geom.nw;
        is_last  = row_end && row_next == geom.nh;

        px_sum  = {2'b00, r_px} + {1'b0, geom.q};
        rx_sum  = {1'b0, r_rx} + {1'b0, geom.r};
        rx_wrap = rx_sum >= {1'b0, geom.s};
        py_sum  = {1'b0, r_py} + {1'b0, geom.q};
        ry_sum  = {1'b0, r_ry} + {1'b0, geom.r};
        ry_wrap = ry_sum >= {1'b0, geom.s};

        n_load_cnt = r_load_cnt;
        n_col      = r_col;
        n_row      = r_row;
        n_px       = r_px;
        n_rx       = r_rx;
        n_py       = r_py;
        n_ry       = r_ry;

        if (restart) begin
            n_load_cnt = '0;
            n_col      = '0;
            n_row      = '0;
            n_px       = '0;
            n_rx       = '0;
            n_py       = '0;
            n_ry       = '0;
        end else if (do_load) begin
            n_load_cnt = r_load_cnt + COUNT_W'(1);
        end else if (give_pixel) begin
            if (row_end) begin
                n_col = '0;
                n_px  = '0;
                n_rx  = '0;
                n_row = row_next;
                n_py  = DIM_W'(py_sum + (DIM_W+1)'(ry_wrap));
                n_ry  = ry_wrap ? DIM_W'(ry_sum - {1'b0, geom.s}) : DIM_W'(ry_sum);
            end else begin
                n_col = COORD_W'(col_next);
                n_px  = COORD_W'(px_sum + (DIM_W+1)'(rx_wrap));
                n_rx  = rx_wrap ? DIM_W'(rx_sum - {1'b0, geom.s}) : DIM_W'(rx_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_px       <= '0;
            r_rx       <= '0;
            r_py       <= '0;
            r_ry       <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            r_load_cnt <= n_load_cnt;
            r_col      <= n_col;
            r_row      <= n_row;
            r_px       <= n_px;
            r_rx       <= n_rx;
            r_py       <= n_py;
            r_ry       <= n_ry;
            r_res_vld  <= do_fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_fetch) begin
            r_res_status <= fetch_status;
            r_res_col    <= give_pixel ? r_col : '0;
            r_res_row    <= give_pixel ? COORD_W'(r_row) : '0;
            r_res_last   <= give_pixel && is_last;
            r_res_nw     <= geom.nw;
            r_res_nh     <= geom.nh;
        end
    end

    assign o_result_strobe = r_res_vld;

    always_comb begin
        o_result.pixel_out     = (r_res_status == ST_PIXEL) ? ram_rdata : '0;
        o_result.out_col       = r_res_col;
        o_result.out_row       = r_res_row;
        o_result.scaled_width  = r_res_nw;
        o_result.scaled_height = r_res_nh;
        o_result.last_pixel    = r_res_last;
        o_result.status        = r_res_status;
    end

`ifndef SYNTHESIS
    a_strobe_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(start && !busy && i_item.opcode == OP_FETCH))
        else $error("Result strobe without a fetch accepted in the cycle before.");

    a_last_only_on_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_result.last_pixel |-> o_result.status == ST_PIXEL)
        else $error("Last mark on a status result.");

    a_load_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> r_load_cnt <= geom.total)
        else $error("Load count ran past the frame size.");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && geom.nw != '0 && r_row < geom.nh |-> {1'b0, r_col} < geom.nw)
        else $error("Emit column ran past the scaled width.");
`endif

endmodule

`default_nettype wire
